// ===== sv/iibm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iibm_pkg
// shared types and constants of the integral image box mean block
// ----------------------------------------------------------------------------
package iibm_pkg;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 9;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE     = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WAIT,
        ST_WR_DO,
        ST_Q_SETUP,
        ST_Q_RD,
        ST_Q_ACC,
        ST_Q_DIV,
        ST_OUT
    } iibm_state_t;

    typedef struct packed {
        logic accept;
        logic wr_read;
        logic wr_commit;
        logic q_setup;
        logic q_read;
        logic q_acc;
        logic div_start;
        logic out_load;
        logic [1:0] corner;
    } iibm_cmd_t;

    typedef struct packed {
        logic is_query;
        logic loaded;
        logic div_done;
    } iibm_sts_t;

endpackage

// ===== sv/iibm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iibm_ctrl
// sequencer for pixel writes and box queries
// ----------------------------------------------------------------------------
module iibm_ctrl
    import iibm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  iibm_sts_t sts,
    output iibm_cmd_t cmd
);

    iibm_state_t state_reg, state_next;
    logic [1:0]  corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (sts.is_query == FUNC_QUERY) ? ST_Q_SETUP : ST_WR_RD;
                end
            end
            ST_WR_RD:   state_next = ST_WR_WAIT;
            ST_WR_WAIT: state_next = ST_WR_DO;
            ST_WR_DO:   state_next = ST_IDLE;
            ST_Q_SETUP:
            begin
                corner_next = 2'd0;
                state_next  = sts.loaded ? ST_Q_RD : ST_OUT;
            end
            ST_Q_RD:    state_next = ST_Q_ACC;
            ST_Q_ACC:
            begin
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd3) ? ST_Q_DIV : ST_Q_RD;
            end
            ST_Q_DIV:   state_next = sts.div_done ? ST_OUT : ST_Q_DIV;
            ST_OUT:     state_next = out_ready ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.corner = corner_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_WR_RD:   cmd.wr_read = 1'b1;
            ST_WR_WAIT: ;
            ST_WR_DO:   cmd.wr_commit = 1'b1;
            ST_Q_SETUP: cmd.q_setup = 1'b1;
            ST_Q_RD:    cmd.q_read = 1'b1;
            ST_Q_ACC:
            begin
                cmd.q_acc     = 1'b1;
                cmd.div_start = (corner_reg == 2'd3);
            end
            ST_Q_DIV:   cmd.out_load = sts.div_done;
            ST_OUT:     out_valid = 1'b1;
            default:    ;
        endcase
    end

endmodule

// ===== sv/iibm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iibm_div
// radix-2 restoring divider, signed dividend, unsigned divisor, truncating
// ----------------------------------------------------------------------------
module iibm_div
    import iibm_pkg::*;
#(
    parameter int NB = 32,
    parameter int DB = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NB-1:0] dividend,
    input  logic        [DB-1:0] divisor,
    output logic                 done,
    output logic signed [NB:0]   quotient
);

    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] q_reg, q_next;
    logic [NB:0]   r_reg, r_next;
    logic [DB-1:0] d_reg;
    logic          neg_reg;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NB:0]   shifted;
    logic [NB:0]   trial;

    always_comb
    begin
        shifted   = {r_reg[NB-1:0], q_reg[NB-1]};
        trial     = shifted - {{(NB+1-DB){1'b0}}, d_reg};
        q_next    = {q_reg[NB-2:0], ~trial[NB]};
        r_next    = trial[NB] ? shifted : trial;
        cnt_next  = cnt_reg - CB'(1);
        busy_next = busy_reg && (cnt_reg != CB'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CB'(NB);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[NB-1];
            q_reg   <= dividend[NB-1] ? NB'(-dividend) : dividend;
            r_reg   <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done     = busy_reg && (cnt_reg == CB'(1));
    assign quotient = neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});

endmodule

// ===== sv/iibm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iibm_dp
// datapath: summed-area table memory, write position, box clipping, corners
// ----------------------------------------------------------------------------
module iibm_dp
    import iibm_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  iibm_cmd_t               cmd,
    output iibm_sts_t               sts,
    input  logic                    in_func,
    input  logic [SAMPLE_BITS-1:0]  in_pixel,
    input  logic [7:0]              in_qx,
    input  logic [7:0]              in_qy,
    input  logic                    cfg_wr,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [CFG_BITS-1:0]     cfg_val,
    output logic [15:0]             box_mean,
    output logic [31:0]             window_sum,
    output logic [16:0]             pixel_count,
    output logic                    valid_res
);

    localparam int XB    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AB    = XB + YB;
    localparam int DEPTH = 1 << AB;
    localparam int CW    = 13;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;
    logic [AB-1:0] addr;
    logic          mem_rd;

    logic [CFG_BITS-1:0] fw_reg, fh_reg, bs_reg;
    logic [CW-1:0] w_eff, h_eff;
    logic [XB-1:0] col_reg;
    logic [YB-1:0] row_reg;
    logic [31:0]   rsum_reg;
    logic          loaded_reg;
    logic [SAMPLE_BITS-1:0] pix_reg;
    logic [7:0]    qx_reg, qy_reg;

    logic [CW-1:0] l_reg, t_reg, r_reg, b_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   acc_next;
    logic [16:0]   cnt_reg;
    logic          qvalid_reg;
    logic [15:0]   mean_reg;
    logic [31:0]   rsum_new;

    logic [CW-1:0] qx_c, qy_c, off, lx, ty, rx, by;
    logic [CW-1:0] ax, ay;
    logic          use_c;
    logic          div_done;
    logic signed [32:0] quot;

    function automatic logic [CW-1:0] eff(input logic [CFG_BITS-1:0] v, input int mx);
        logic [CW-1:0] e;
        e = CW'(v);
        if (v == '0) e = CW'(1);
        else if (e > CW'(mx)) e = CW'(mx);
        return e;
    endfunction

    assign w_eff = eff(fw_reg, MAX_WIDTH);
    assign h_eff = eff(fh_reg, MAX_HEIGHT);

    assign sts.is_query = in_func;
    assign sts.loaded   = loaded_reg;
    assign sts.div_done = div_done;

    // box clipping
    always_comb
    begin
        qx_c = (CW'(qx_reg) > w_eff - CW'(1)) ? w_eff - CW'(1) : CW'(qx_reg);
        qy_c = (CW'(qy_reg) > h_eff - CW'(1)) ? h_eff - CW'(1) : CW'(qy_reg);
        off  = CW'(bs_reg >> 1);
        lx   = (qx_c > off) ? qx_c - off : '0;
        ty   = (qy_c > off) ? qy_c - off : '0;
        rx   = (qx_c + off > w_eff - CW'(1)) ? w_eff - CW'(1) : qx_c + off;
        by   = (qy_c + off > h_eff - CW'(1)) ? h_eff - CW'(1) : qy_c + off;
    end

    // corner select: 0 = (r,b) add, 1 = (l-1,t-1) add, 2 = (r,t-1) sub, 3 = (l-1,b) sub
    always_comb
    begin
        ax    = r_reg;
        ay    = b_reg;
        use_c = 1'b1;
        case (cmd.corner)
            2'd0: begin ax = r_reg; ay = b_reg; use_c = 1'b1; end
            2'd1: begin ax = l_reg - CW'(1); ay = t_reg - CW'(1);
                        use_c = (l_reg != '0) && (t_reg != '0); end
            2'd2: begin ax = r_reg; ay = t_reg - CW'(1); use_c = (t_reg != '0); end
            default: begin ax = l_reg - CW'(1); ay = b_reg; use_c = (l_reg != '0); end
        endcase
    end

    always_comb
    begin
        if (cmd.wr_read || cmd.wr_commit)
        begin
            addr = {YB'(row_reg - YB'(1)), col_reg};
            if (cmd.wr_commit) addr = {row_reg, col_reg};
        end
        else
        begin
            addr = {ay[YB-1:0], ax[XB-1:0]};
        end
        mem_rd = cmd.wr_read || cmd.q_read;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.q_acc && use_c)
        begin
            acc_next = (cmd.corner[1]) ? acc_reg - rd_reg : acc_reg + rd_reg;
        end
    end

    assign rsum_new = rsum_reg + 32'(signed'(pix_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_commit)
        begin
            mem[addr] <= rsum_new + ((row_reg != '0) ? rd_reg : 32'd0);
        end
        if (mem_rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg  <= in_pixel;
            qx_reg   <= in_qx;
            qy_reg   <= in_qy;
        end
        if (cmd.q_setup)
        begin
            l_reg   <= lx;
            t_reg   <= ty;
            r_reg   <= rx;
            b_reg   <= by;
            acc_reg <= '0;
            cnt_reg <= 17'(17'(rx - lx + CW'(1)) * 17'(by - ty + CW'(1)));
        end
        if (cmd.q_acc)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load)
        begin
            mean_reg <= (quot > 33'sd32767) ? 16'h7fff :
                        (quot < -33'sd32768) ? 16'h8000 : quot[15:0];
        end
    end

    iibm_div #(.NB(32), .DB(17)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (signed'(acc_next)),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= CFG_BITS'(256);
            fh_reg     <= CFG_BITS'(256);
            bs_reg     <= CFG_BITS'(3);
            col_reg    <= '0;
            row_reg    <= '0;
            rsum_reg   <= '0;
            loaded_reg <= 1'b0;
            qvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
                    begin
                        if (cfg_idx == REG_FRAME_WIDTH) fw_reg <= cfg_val;
                        else fh_reg <= cfg_val;
                        col_reg    <= '0;
                        row_reg    <= '0;
                        rsum_reg   <= '0;
                        loaded_reg <= 1'b0;
                    end
                    REG_BOX_SIZE: bs_reg <= cfg_val;
                    default: ;
                endcase
            end
            if (cmd.q_setup)
            begin
                qvalid_reg <= loaded_reg;
            end
            if (cmd.wr_read && col_reg == '0 && row_reg == '0)
            begin
                loaded_reg <= 1'b0;
            end
            if (cmd.wr_commit)
            begin
                if (CW'(col_reg) + CW'(1) >= w_eff)
                begin
                    col_reg  <= '0;
                    rsum_reg <= '0;
                    if (CW'(row_reg) + CW'(1) >= h_eff)
                    begin
                        row_reg    <= '0;
                        loaded_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg <= row_reg + YB'(1);
                    end
                end
                else
                begin
                    col_reg  <= col_reg + XB'(1);
                    rsum_reg <= rsum_new;
                end
            end
        end
    end

    assign box_mean    = qvalid_reg ? mean_reg : 16'd0;
    assign window_sum  = qvalid_reg ? acc_reg  : 32'd0;
    assign pixel_count = qvalid_reg ? cnt_reg  : 17'd0;
    assign valid_res   = qvalid_reg;

endmodule

// ===== sv/integral_image_box_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_image_box_mean
// summed-area table box filter over one stored frame
// ----------------------------------------------------------------------------
// usage:
//   s_axis beats carry either a pixel write (func 0) or a box query (func 1).
//   pixel writes arrive in raster order and fill the table; no output beat.
//   a query produces one m_axis beat: mean, window sum, pixel count, valid.
//   cfg channel writes frame_width (0), frame_height (1), box_size (2);
//   frame size writes restart the frame at the origin.
// timing:
//   write: each beat is a read-modify-write of the single table port
//   (read the entry above, then store); the next beat waits for the store.
//   query: four corner reads of the single table port plus a 32-step
//   serial divider for the mean.
//   a query before a complete frame returns zeros without table reads.
// reset: clears the write position, running sum and loaded flag; table
//   contents are left undefined; size registers return to 256x256, box 3.
// stall: the result beat holds on m_axis until taken; no new beat is
//   accepted meanwhile.
// ----------------------------------------------------------------------------
module integral_image_box_mean
    import iibm_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic                    s_axis_tuser,   // func
    input  logic [31:0]             s_axis_tdata,   // pixel_value[15:0], query_x, query_y
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [71:0]             m_axis_tdata,   // box_mean, window_sum, pixel_count, valid_res, pad
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    iibm_cmd_t   cmd;
    iibm_sts_t   sts;
    logic [15:0] box_mean;
    logic [31:0] window_sum;
    logic [16:0] pixel_count;
    logic        valid_res;

    assign cfg_ready = 1'b1;

    iibm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    iibm_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_func     (s_axis_tuser),
        .in_pixel    (SAMPLE_BITS'(s_axis_tdata[15:0])),
        .in_qx       (s_axis_tdata[23:16]),
        .in_qy       (s_axis_tdata[31:24]),
        .cfg_wr      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_val     (cfg_data),
        .box_mean    (box_mean),
        .window_sum  (window_sum),
        .pixel_count (pixel_count),
        .valid_res   (valid_res)
    );

    assign m_axis_tdata = {6'd0, valid_res, pixel_count, window_sum, box_mean};

`ifndef SYNTH
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[65] |-> m_axis_tdata[64:0] == 65'd0)
        else $error("invalid result not zero");
`endif

endmodule

// ===== test/integral_image_box_mean_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_image_box_mean_tb
// checks the summed-area table box filter against a behavioral scoreboard
// ----------------------------------------------------------------------------
// pixel frames of many sizes are streamed in raster order and box queries are
// mixed in, with random gaps on both sides; every query result is compared
// field by field with a prediction built from an in-testbench copy of the
// table, the write position and the size registers.
// ----------------------------------------------------------------------------
module integral_image_box_mean_tb;
    import iibm_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic signed [15:0] box_mean;
        logic [31:0]        window_sum;
        logic [16:0]        pixel_count;
        logic               valid_res;
    } box_result_t;

    class box_mean_scoreboard;
        bit [31:0]   sat_table [65536];
        bit [31:0]   row_sum;
        int          wr_col;
        int          wr_row;
        bit          loaded;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned box_reg;
        box_result_t expected_q [$];
        int          errors;

        function new();
            foreach (sat_table[i])
                sat_table[i] = '0;
            row_sum    = '0;
            wr_col     = 0;
            wr_row     = 0;
            loaded     = 0;
            width_reg  = 256;
            height_reg = 256;
            box_reg    = 3;
            errors     = 0;
        endfunction

        function int eff_dim(int unsigned v);
            if (v == 0)
                return 1;
            if (v > 256)
                return 256;
            return v;
        endfunction

        function void restart();
            row_sum = '0;
            wr_col  = 0;
            wr_row  = 0;
            loaded  = 0;
        endfunction

        function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
            if (idx == REG_FRAME_WIDTH)
            begin
                width_reg = v;
                restart();
            end
            else if (idx == REG_FRAME_HEIGHT)
            begin
                height_reg = v;
                restart();
            end
            else if (idx == REG_BOX_SIZE)
                box_reg = v;
        endfunction

        function void note_beat(logic func, logic [15:0] pix, logic [7:0] qx_in,
                                logic [7:0] qy_in);
            int          w;
            int          h;
            int          off;
            int          qx;
            int          qy;
            int          l;
            int          t;
            int          r;
            int          b;
            bit [31:0]   above;
            bit [31:0]   ca;
            bit [31:0]   cb;
            bit [31:0]   cc;
            bit [31:0]   cd;
            bit [31:0]   s;
            longint      mean;
            longint      cnt;
            box_result_t res;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            if (func == FUNC_WRITE)
            begin
                if (loaded && wr_col == 0 && wr_row == 0)
                    loaded = 0;
                row_sum = row_sum + {{16{pix[15]}}, pix};
                above = (wr_row > 0) ? sat_table[(wr_row - 1) * 256 + wr_col] : '0;
                sat_table[wr_row * 256 + wr_col] = row_sum + above;
                wr_col++;
                if (wr_col >= w)
                begin
                    wr_col  = 0;
                    row_sum = '0;
                    wr_row++;
                    if (wr_row >= h)
                    begin
                        wr_row = 0;
                        loaded = 1;
                    end
                end
                return;
            end
            if (!loaded)
            begin
                res.box_mean    = '0;
                res.window_sum  = '0;
                res.pixel_count = '0;
                res.valid_res   = 1'b0;
                expected_q.push_back(res);
                return;
            end
            off = box_reg / 2;
            qx  = (qx_in > w - 1) ? w - 1 : qx_in;
            qy  = (qy_in > h - 1) ? h - 1 : qy_in;
            l   = (qx > off) ? qx - off : 0;
            t   = (qy > off) ? qy - off : 0;
            r   = (qx + off > w - 1) ? w - 1 : qx + off;
            b   = (qy + off > h - 1) ? h - 1 : qy + off;
            cd  = sat_table[b * 256 + r];
            ca  = (l > 0 && t > 0) ? sat_table[(t - 1) * 256 + l - 1] : '0;
            cb  = (t > 0) ? sat_table[(t - 1) * 256 + r] : '0;
            cc  = (l > 0) ? sat_table[b * 256 + l - 1] : '0;
            s   = cd + ca - cb - cc;
            cnt = (r - l + 1) * (b - t + 1);
            mean = longint'($signed(s)) / cnt;
            if (mean > 32767)
                mean = 32767;
            if (mean < -32768)
                mean = -32768;
            res.box_mean    = mean[15:0];
            res.window_sum  = s;
            res.pixel_count = cnt[16:0];
            res.valid_res   = 1'b1;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [71:0] d);
            box_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no query pending: %h", d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (d[15:0] !== e.box_mean)
            begin
                $error("box_mean expected %0d actual %0d", e.box_mean, $signed(d[15:0]));
                errors++;
            end
            if (d[47:16] !== e.window_sum)
            begin
                $error("window_sum expected %0d actual %0d", $signed(e.window_sum),
                       $signed(d[47:16]));
                errors++;
            end
            if (d[64:48] !== e.pixel_count)
            begin
                $error("pixel_count expected %0d actual %0d", e.pixel_count, d[64:48]);
                errors++;
            end
            if (d[65] !== e.valid_res)
            begin
                $error("valid_res expected %0b actual %0b", e.valid_res, d[65]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic                    s_axis_tuser;
    logic [31:0]             s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [71:0]             m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    box_mean_scoreboard sb;
    int                 beats_sent;
    bit                 steady;

    integral_image_box_mean u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 11)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_beat(logic func, logic [15:0] pix, logic [7:0] qx, logic [7:0] qy);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {qy, qx, pix};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat(func, pix, qx, qy);
        beats_sent++;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic write_pixel(logic [15:0] pix);
        send_beat(FUNC_WRITE, pix, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic query_box(logic [7:0] qx, logic [7:0] qy);
        send_beat(FUNC_QUERY, 16'($urandom_range(0, 65535)), qx, qy);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_BITS-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return CFG_BITS'(0);
            1: return CFG_BITS'(256);
            2: return CFG_BITS'($urandom_range(257, 511));
            default: return CFG_BITS'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic load_frame();
        int n;
        n = sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg);
        repeat (n) write_pixel(rand_pixel());
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (steady || $urandom_range(0, 9) < 6)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b0;
        end
    end

    initial
    begin
        logic [CFG_BITS-1:0] wv;
        logic [CFG_BITS-1:0] hv;
        int                  nq;
        sb            = new();
        beats_sent    = 0;
        steady        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries before any frame is loaded
        query_box(8'd0, 8'd0);
        query_box(8'd255, 8'd255);

        write_reg(REG_FRAME_WIDTH, 9'd3);
        write_reg(REG_FRAME_HEIGHT, 9'd2);
        write_reg(REG_BOX_SIZE, 9'd0);
        write_pixel(16'h7fff);
        write_pixel(16'h8000);
        write_pixel(16'h0000);
        query_box(8'd1, 8'd1);
        write_pixel(16'hffff);
        write_pixel(16'h0001);
        write_pixel(16'h3039);
        query_box(8'd0, 8'd0);
        query_box(8'd2, 8'd1);
        query_box(8'd255, 8'd255);
        query_box(8'd255, 8'd0);
        write_reg(REG_BOX_SIZE, 9'd511);
        query_box(8'd1, 8'd0);
        query_box(8'd170, 8'd85);
        write_reg(REG_UNMAPPED, 9'h1ff);
        query_box(8'd0, 8'd1);
        // a write after a full frame starts the next one
        write_pixel(16'h5555);
        query_box(8'd0, 8'd0);

        while (beats_sent < 850)
        begin
            steady = ($urandom_range(0, 4) == 0);
            wv = rand_dim();
            hv = rand_dim();
            if (wv == 0 || wv > 8)
                hv = CFG_BITS'(1);
            else if (hv == 0 || hv > 8)
                wv = CFG_BITS'(1);
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_FRAME_WIDTH, wv);
                write_reg(REG_FRAME_HEIGHT, hv);
            end
            else
            begin
                write_reg(REG_FRAME_HEIGHT, hv);
                write_reg(REG_FRAME_WIDTH, wv);
            end
            case ($urandom_range(0, 5))
                0: write_reg(REG_BOX_SIZE, 9'd511);
                1: write_reg(REG_BOX_SIZE, CFG_BITS'($urandom_range(0, 511)));
                default: write_reg(REG_BOX_SIZE, CFG_BITS'($urandom_range(0, 9)));
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNMAPPED, CFG_BITS'($urandom_range(0, 511)));
            if ($urandom_range(0, 5) == 0)
                query_box(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 2))
            begin
                if (beats_sent >= 850)
                    break;
                load_frame();
                nq = $urandom_range(3, 10);
                repeat (nq)
                begin
                    if ($urandom_range(0, 9) == 0)
                        write_pixel(rand_pixel());
                    else if ($urandom_range(0, 3) == 0)
                        query_box(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    else
                        query_box(8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
